// ===== rtl/ibsd_pkg.sv =====
// shared types and constants for the ibus servo frame decoder
// no dependencies
package ibsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 5;
  localparam int unsigned SumW   = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IndexW = 4;
  localparam int unsigned ValueW = 12;

  localparam logic [ByteW-1:0] SYNC_FIRST    = 8'h20;
  localparam logic [ByteW-1:0] SYNC_SECOND   = 8'h40;
  localparam logic [SumW-1:0]  CHECKSUM_SEED = 16'hff9f;
  localparam logic [PosW-1:0]  IDLE_POS      = 5'd30;

  localparam logic [KindW-1:0] EV_CHANNEL = 2'd0;
  localparam logic [KindW-1:0] EV_GOOD    = 2'd1;
  localparam logic [KindW-1:0] EV_BAD     = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
  } event_t;

endpackage

// ===== rtl/ibsd_in_reg.sv =====
// input register for received bytes
// depends on ibsd_pkg
module ibsd_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  logic [ibsd_pkg::ByteW-1:0] s_byte,
  input  logic                      advance,
  output logic                      held_valid,
  output logic [ibsd_pkg::ByteW-1:0] held_byte
);
  import ibsd_pkg::*;

  assign s_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      held_byte <= s_byte;
    end
  end

endmodule

// ===== rtl/ibsd_decode.sv =====
// frame state and per-byte decode: sync detect, pair counter, checksum
// depends on ibsd_pkg
module ibsd_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [ibsd_pkg::ByteW-1:0] rx_byte,
  output logic                      produce,
  output ibsd_pkg::event_t          ev
);
  import ibsd_pkg::*;

  logic [ByteW-1:0] previous_byte;
  logic [PosW-1:0]  pair_position;
  logic [PosW-1:0]  pair_position_next;
  logic [SumW-1:0]  running_checksum;
  logic [SumW-1:0]  running_checksum_next;

  logic             sync;
  logic             idle;
  logic [PosW-1:0]  pos_inc;
  logic [SumW-1:0]  pair;
  logic [ByteW:0]   byte_sum;

  always_comb begin
    sync     = (previous_byte == SYNC_FIRST) && (rx_byte == SYNC_SECOND);
    idle     = pair_position >= IDLE_POS;
    pos_inc  = pair_position + 1'b1;
    pair     = {rx_byte, previous_byte};
    byte_sum = {1'b0, previous_byte} + {1'b0, rx_byte};

    pair_position_next    = pair_position;
    running_checksum_next = running_checksum;
    produce               = 1'b0;
    ev.kind               = EV_CHANNEL;
    ev.index              = '0;
    ev.value              = '0;

    if (sync) begin
      pair_position_next    = '0;
      running_checksum_next = CHECKSUM_SEED;
    end else if (idle) begin
      pair_position_next = IDLE_POS;
    end else begin
      pair_position_next = pos_inc;
      if (!pos_inc[0]) begin
        produce = 1'b1;
        if (pos_inc == IDLE_POS) begin
          ev.kind = (running_checksum == pair) ? EV_GOOD : EV_BAD;
        end else begin
          ev.index              = pos_inc[PosW-1:1] - 1'b1;
          ev.value              = pair[ValueW-1:0];
          running_checksum_next = running_checksum - {{(SumW-ByteW-1){1'b0}}, byte_sum};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte    <= '0;
      pair_position    <= IDLE_POS;
      running_checksum <= '0;
    end else if (advance) begin
      previous_byte    <= rx_byte;
      pair_position    <= pair_position_next;
      running_checksum <= running_checksum_next;
    end
  end

endmodule

// ===== rtl/ibsd_out_reg.sv =====
// result register toward the downstream side
// depends on ibsd_pkg
module ibsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             produce,
  input  ibsd_pkg::event_t ev_in,
  output logic             m_valid,
  input  logic             m_ready,
  output ibsd_pkg::event_t ev_out
);
  import ibsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= produce;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      ev_out <= ev_in;
    end
  end

endmodule

// ===== rtl/ibus_servo_frame_decoder_core.sv =====
// top level of the ibus servo frame decoder
// depends on ibsd_pkg, ibsd_in_reg, ibsd_decode, ibsd_out_reg
//
// usage:
//   s_* takes one received serial byte per item in s_tdata.
//   m_* gives at most one event per byte: m_tuser is the event kind
//   (0 channel value, 1 frame good, 2 frame bad), m_tdata carries the
//   channel index and the 12-bit channel value (zero for frame events).
//   a 0x20, 0x40 byte pair resyncs at any point; the next 14 pairs give
//   channels 0 to 13, the 15th is checked against the running checksum,
//   then the block ignores bytes until the next sync.
// timing:
//   one byte per cycle sustained while m_tready is high; a byte waits in
//   the input register, then its event is registered in the result register.
//   the state update is a single pass of compare, 5-bit increment and 16-bit subtract.
// reset:
//   rst clears both valid flags, idles the pair counter, zeroes previous byte and checksum
// stall:
//   while m_tready is low and an event waits, the input register holds
//   one more byte, then s_tready drops until the event is taken.
module ibus_servo_frame_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // channel_index [3:0], channel_value [15:4]
  output logic [1:0]  m_tuser    // event_kind
);
  import ibsd_pkg::*;

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             advance;
  logic             produce;
  event_t           ev;
  event_t           ev_out;

  assign advance = held_valid && (!m_tvalid || m_tready);

  ibsd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_byte     (s_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  ibsd_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (held_byte),
    .produce (produce),
    .ev      (ev)
  );

  ibsd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .produce (produce),
    .ev_in   (ev),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .ev_out  (ev_out)
  );

  assign m_tuser = ev_out.kind;
  assign m_tdata = {ev_out.value, ev_out.index};

  a_frame_event_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != EV_CHANNEL) |-> (m_tdata == '0))
    else $error("frame event carries channel data");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_CHANNEL) |-> (m_tdata[3:0] <= 4'd13))
    else $error("channel index out of range");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("bad event kind");

  a_new_event_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance))
    else $error("event appeared without a processed byte");

endmodule
